### rtl/core/slcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_pkg: shared constants for the sonar log compression pixel pipeline
// Fixed-point formats, floor and span of the log window, reciprocal scale.
// ----------------------------------------------------------------------------
package slcp_pkg;

	// fractional bits of the log2 value (range 8..24)
	localparam int unsigned FRAC_BITS = 16;

	localparam int unsigned IN_W   = 32;
	localparam int unsigned PIX_W  = 8;
	localparam int unsigned LEAD_W = 5;                 // leading-one position, 0..31
	localparam int unsigned MANT_W = 32;                // mantissa, Q1.31
	localparam int unsigned L_W    = LEAD_W + FRAC_BITS; // log2 value, Q5.FRAC_BITS

	// window floor: 0.74 * 32, truncated
	localparam logic [L_W-1:0] LOG_LO =
		L_W'((64'd2368 << FRAC_BITS) / 64'd100);
	// window span: 0.26 * 32, rounded
	localparam logic [L_W-1:0] LOG_SPAN =
		L_W'(((64'd832 << FRAC_BITS) + 64'd50) / 64'd100);

	// (L - LOG_LO) * 255 fits here
	localparam int unsigned P_W = L_W + PIX_W;

	// q = floor(p / LOG_SPAN) = (p * RECIP) >> RSHIFT, exact for all p < 2**P_W,
	// since the reciprocal error stays below LOG_SPAN < 2**(RSHIFT - P_W)
	localparam int unsigned RSHIFT = 2 * FRAC_BITS + 17;
	localparam int unsigned R_W    = FRAC_BITS + 14;
	localparam logic [127:0] RECIP_FULL =
		((128'd1 << RSHIFT) + 128'(LOG_SPAN) - 128'd1) / 128'(LOG_SPAN);
	localparam logic [R_W-1:0] RECIP = RECIP_FULL[R_W-1:0];
	localparam int unsigned PROD_W = P_W + R_W;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	// register stages: leading one, normalize, one per fraction bit,
	// difference, multiply, output
	localparam int unsigned NSTAGE = FRAC_BITS + 5;

endpackage

### rtl/core/sonar_log_compress_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_log_compress_pixel: 32-bit sonar intensity to 8-bit log pixel
// Fixed-point log2 by leading-one detect and repeated squaring, then a linear
// map of the upper part of the log range onto 0..255 with clamping.
// ----------------------------------------------------------------------------
//
//  channel     | handshake                        | payload
//  ------------+----------------------------------+----------------------------
//  input item  | intensity_valid, intensity_ready | intensity [31:0] unsigned
//  result item | pixel_valid, pixel_ready         | pixel     [7:0]  unsigned
//
//  One item per clock while pixel_ready holds. Stages in order: leading one,
//  normalize, one squaring per fraction bit, difference, multiply, output.
//  arst_n clears all stage valid bits; data registers are not reset.
//  Each stage holds while the one after it is full and stalled, so a stall
//  at the output lets empty stages behind it fill up; nothing is dropped.
//
module sonar_log_compress_pixel
	import slcp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              intensity_valid,
	output logic              intensity_ready,
	input  logic [IN_W-1:0]   intensity,
	output logic              pixel_valid,
	input  logic              pixel_ready,
	output logic [PIX_W-1:0]  pixel
);

	// stage map
	localparam int unsigned ST_LOD  = 0;
	localparam int unsigned ST_NORM = 1;
	localparam int unsigned ST_SQ0  = 2;
	localparam int unsigned ST_DIFF = FRAC_BITS + 2;
	localparam int unsigned ST_MUL  = FRAC_BITS + 3;
	localparam int unsigned ST_OUT  = FRAC_BITS + 4;

	logic [NSTAGE-1:0] vld_q;    // valid bit per stage
	logic [NSTAGE-1:0] adv;      // stage loads this cycle

	// a stage may load when it is empty or its contents move on
	always_comb begin
		adv[NSTAGE-1] = !vld_q[NSTAGE-1] || pixel_ready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign intensity_ready = adv[ST_LOD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= intensity_valid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---- stage 1: clamp to at least 1, find the leading one ----
	logic [IN_W-1:0]   x_in;
	logic [LEAD_W-1:0] lead_in;
	logic [IN_W-1:0]   x_s1;
	logic [LEAD_W-1:0] lead_s1;

	assign x_in = (intensity == '0) ? IN_W'(1) : intensity;

	always_comb begin
		lead_in = '0;
		for (int i = 1; i < IN_W; i++) begin
			if (x_in[i]) begin
				lead_in = LEAD_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_LOD]) begin
			x_s1    <= x_in;
			lead_s1 <= lead_in;
		end
	end

	// ---- stage 2: normalize to Q1.31; then one squaring per stage ----
	// index j of these arrays is the register of stage ST_NORM + j
	logic [MANT_W-1:0]    mant_s [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_s [FRAC_BITS+1];
	logic [LEAD_W-1:0]    lead_s [FRAC_BITS+1];

	always_ff @(posedge clk) begin
		if (adv[ST_NORM]) begin
			// shift left by 31 - lead, which is ~lead for a 5-bit position
			mant_s[0] <= x_s1 << (~lead_s1);
			frac_s[0] <= '0;
			lead_s[0] <= lead_s1;
		end
	end

	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W-1:0]   mant_nx;

		// Q1.31 squared is Q2.62; keep the bits down to 2**-31 (truncating)
		assign sq = (2*MANT_W)'(mant_s[g]) * (2*MANT_W)'(mant_s[g]);
		// square reached 2.0: fraction bit set and halve (also truncating)
		assign mant_nx = sq[2*MANT_W-1] ? sq[2*MANT_W-1:MANT_W]
		                                : sq[2*MANT_W-2:MANT_W-1];

		always_ff @(posedge clk) begin
			if (adv[ST_SQ0+g]) begin
				mant_s[g+1] <= mant_nx;
				frac_s[g+1] <= {frac_s[g][FRAC_BITS-2:0], sq[2*MANT_W-1]};
				lead_s[g+1] <= lead_s[g];
			end
		end
	end

	// ---- difference stage: distance above the floor, times 255 ----
	logic [L_W-1:0] log_val;
	logic [L_W-1:0] diff;
	logic [P_W-1:0] scaled;
	logic           zero_sd;
	logic [P_W-1:0] scaled_sd;

	assign log_val = {lead_s[FRAC_BITS], frac_s[FRAC_BITS]};
	assign diff    = log_val - LOG_LO;
	assign scaled  = {diff, {PIX_W{1'b0}}} - P_W'(diff);

	always_ff @(posedge clk) begin
		if (adv[ST_DIFF]) begin
			zero_sd   <= (log_val <= LOG_LO);
			scaled_sd <= scaled;
		end
	end

	// ---- multiply stage: divide by the span through its reciprocal ----
	logic              zero_sm;
	logic [PROD_W-1:0] prod_sm;

	always_ff @(posedge clk) begin
		if (adv[ST_MUL]) begin
			zero_sm <= zero_sd;
			prod_sm <= PROD_W'(scaled_sd) * PROD_W'(RECIP);
		end
	end

	// ---- output stage: clamp to 0..255 ----
	logic [PIX_W-1:0] pix_nx;
	logic [PIX_W-1:0] pix_so;

	always_comb begin
		if (zero_sm) begin
			pix_nx = '0;
		end else if (prod_sm[PROD_W-1:RSHIFT+PIX_W] != '0) begin
			pix_nx = PIX_MAX;
		end else begin
			pix_nx = prod_sm[RSHIFT+PIX_W-1:RSHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			pix_so <= pix_nx;
		end
	end

	assign pixel_valid = vld_q[ST_OUT];
	assign pixel       = pix_so;

endmodule

### rtl/core/slcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcp_props: port-level checks for the log compression pixel pipeline
// Output hold under stall, and input readiness against output state.
// ----------------------------------------------------------------------------
module slcp_props (
	input logic       clk,
	input logic       arst_n,
	input logic       intensity_valid,
	input logic       intensity_ready,
	input logic [31:0] intensity,
	input logic       pixel_valid,
	input logic       pixel_ready,
	input logic [7:0] pixel
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid)
		else $error("result item withdrawn under stall");

	// a stalled result item keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> $stable(pixel))
		else $error("pixel changed under stall");

	// an empty output stage never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_valid |-> intensity_ready)
		else $error("input blocked while output empty");

	// when the output drains, the whole pipe moves and takes an item
	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ready |-> intensity_ready)
		else $error("input blocked while output drains");

endmodule

bind sonar_log_compress_pixel slcp_props u_slcp_props (.*);
